// ----- rtl/core/md5_message_digest_assert.svh -----
// Assertion macros used by the digest checker.
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MD5_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("md5 digest: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("md5 digest: next-cycle check failed");

`endif

// ----- rtl/core/md5_pkg.sv -----
package md5_pkg;

  // Working variables of one compression.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_abcd_t;

  localparam logic [31:0] INIT_CHAIN [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by {phase, round[1:0]}.
  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [1:0] LAST_INDEX = 2'd3;

endpackage

// ----- rtl/core/md5_round.sv -----
module md5_round (
  input  logic [5:0]        rnd,
  input  md5_pkg::md5_abcd_t work,
  input  logic [31:0]       msg,
  output logic [3:0]        msg_idx,
  output md5_pkg::md5_abcd_t work_next
);

  logic [1:0]  phase;
  logic [3:0]  r4;
  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  amt;
  logic [63:0] dbl;

  assign phase = rnd[5:4];
  assign r4    = rnd[3:0];

  // Select the round function and the message word for this round
  always_comb begin
    unique case (phase)
      2'd0: begin
        f       = (work.b & work.c) | (~work.b & work.d);
        msg_idx = r4;
      end
      2'd1: begin
        f       = (work.b & work.d) | (work.c & ~work.d);
        msg_idx = 4'd1 + {r4[1:0], 2'b00} + r4;
      end
      2'd2: begin
        f       = work.b ^ work.c ^ work.d;
        msg_idx = 4'd5 + {r4[2:0], 1'b0} + r4;
      end
      default: begin
        f       = work.c ^ (work.b | ~work.d);
        msg_idx = {r4[0], 3'b000} - r4;
      end
    endcase
  end

  // Add, rotate left, and shift the working variables along
  assign sum = work.a + f + md5_pkg::ROUND_K[rnd] + msg;
  assign amt = md5_pkg::ROT_AMT[{phase, rnd[1:0]}];
  assign dbl = {sum, sum} << amt;

  always_comb begin
    work_next.a = work.d;
    work_next.b = work.b + dbl[63:32];
    work_next.c = work.b;
    work_next.d = work.c;
  end

endmodule

// ----- rtl/core/md5_message_digest.sv -----
// A byte that fills the 64-byte block starts a compression: 64 rounds through one shared
// round unit, then a fold into the chain.
// End of message: pad bytes one by one up to offset 56, then the length write, one or
// two compressions, then four digest transactions, one per cycle if taken.
// Input is not ready while compressing, padding or emitting the digest.
// Synchronous reset loads the initial chaining value and clears the bit count.
module md5_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] has_byte
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [33:32] word_index, [39:34] zero
  output logic        m_tlast    // last_word
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_t;

  state_t             state;
  state_t             ret_state;
  logic [31:0]        chain [4];
  logic [31:0]        block_words [16];
  logic [63:0]        bit_count;
  logic [5:0]         pad_pos;
  logic               pad_first;
  logic [5:0]         rnd;
  logic [1:0]         out_idx;
  md5_pkg::md5_abcd_t work;
  md5_pkg::md5_abcd_t work_next;
  logic [3:0]         msg_idx;
  logic               in_fire;
  logic               len_wr;
  logic               wr_en;
  logic [5:0]         wr_pos;
  logic [7:0]         wr_byte;

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid & s_tready;
  assign len_wr   = (state == ST_PAD) && !pad_first && (pad_pos == md5_pkg::LEN_POS);

  // Pick the byte written into the block this cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_pos  = pad_pos;
    wr_byte = 8'h00;
    if (in_fire && s_tuser) begin
      wr_en   = 1'b1;
      wr_pos  = bit_count[8:3];
      wr_byte = s_tdata;
    end else if (state == ST_PAD && !len_wr) begin
      wr_en   = 1'b1;
      wr_byte = pad_first ? md5_pkg::PAD_BYTE : 8'h00;
    end
  end

  // Hold the message block
  always_ff @(posedge clk) begin
    if (wr_en) begin
      block_words[wr_pos[5:2]][{wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
    end
    if (len_wr) begin
      block_words[14] <= bit_count[31:0];
      block_words[15] <= bit_count[63:32];
    end
  end

  md5_round u_round (
    .rnd       (rnd),
    .work      (work),
    .msg       (block_words[msg_idx]),
    .msg_idx   (msg_idx),
    .work_next (work_next)
  );

  // Sequence absorb, compression, padding and digest output
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
      for (int i = 0; i < 4; i++) begin
        chain[i] <= md5_pkg::INIT_CHAIN[i];
      end
      bit_count <= 64'd0;
      pad_pos   <= 6'd0;
      pad_first <= 1'b0;
      rnd       <= 6'd0;
      out_idx   <= 2'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser) begin
              bit_count <= bit_count + 64'd8;
            end
            pad_pos   <= s_tuser ? bit_count[8:3] + 6'd1 : bit_count[8:3];
            pad_first <= 1'b1;
            if (s_tuser && bit_count[8:3] == md5_pkg::LAST_POS) begin
              state     <= ST_ROUND;
              ret_state <= s_tlast ? ST_PAD : ST_IDLE;
              rnd       <= 6'd0;
              work      <= {chain[0], chain[1], chain[2], chain[3]};
            end else if (s_tlast) begin
              state <= ST_PAD;
            end
          end
        end
        ST_ROUND: begin
          work <= work_next;
          rnd  <= rnd + 6'd1;
          if (rnd == md5_pkg::LAST_ROUND) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          chain[0] <= chain[0] + work.a;
          chain[1] <= chain[1] + work.b;
          chain[2] <= chain[2] + work.c;
          chain[3] <= chain[3] + work.d;
          state    <= ret_state;
        end
        ST_PAD: begin
          if (len_wr) begin
            state     <= ST_ROUND;
            ret_state <= ST_OUT;
            rnd       <= 6'd0;
            out_idx   <= 2'd0;
            work      <= {chain[0], chain[1], chain[2], chain[3]};
          end else begin
            pad_first <= 1'b0;
            pad_pos   <= pad_pos + 6'd1;
            if (pad_pos == md5_pkg::LAST_POS) begin
              state     <= ST_ROUND;
              ret_state <= ST_PAD;
              rnd       <= 6'd0;
              work      <= {chain[0], chain[1], chain[2], chain[3]};
            end
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            out_idx <= out_idx + 2'd1;
            if (out_idx == md5_pkg::LAST_INDEX) begin
              for (int i = 0; i < 4; i++) begin
                chain[i] <= md5_pkg::INIT_CHAIN[i];
              end
              bit_count <= 64'd0;
              state     <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Drive the digest words from the chaining registers
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {6'd0, out_idx, chain[out_idx]};
  assign m_tlast  = (out_idx == md5_pkg::LAST_INDEX);

endmodule

// ----- rtl/core/md5_message_digest_chk.sv -----
`include "md5_message_digest_assert.svh"

module md5_message_digest_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  // Input is never taken while a digest is on offer
  `MD5_ASSERT_SAME(no_overlap, clk, rst, m_tvalid, !s_tready)

  // A stalled digest transaction keeps its data
  `MD5_ASSERT_NEXT(hold_data, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Words follow one another in index order
  `MD5_ASSERT_NEXT(index_step, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[33:32] == $past(m_tdata[33:32]) + 2'd1))

  // The last word carries index three, and the digest ends there
  `MD5_ASSERT_SAME(last_index, clk, rst, m_tvalid, m_tlast == (m_tdata[33:32] == 2'd3))
  `MD5_ASSERT_NEXT(end_after_last, clk, rst, m_tvalid && m_tready && m_tlast, !m_tvalid)

endmodule

bind md5_message_digest md5_message_digest_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ----- test/tb_md5_message_digest.sv -----
`timescale 1ns / 100ps

package tb_md5_message_digest_pkg;

  // Chaining value loaded at reset and after every digest
  localparam bit [31:0] CHAIN_INIT [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  // Additive constants, one per round
  localparam bit [31:0] MIX_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left-rotate amounts, indexed by {quarter, round[1:0]}
  localparam int ROUND_SHIFT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  localparam bit [7:0] PAD_MARK        = 8'h80;
  localparam int       LENGTH_OFFSET   = 56;
  localparam int       BLOCK_BYTES     = 64;
  localparam bit [1:0] FINAL_WORD_IDX  = 2'd3;

  typedef struct packed {
    bit [31:0] word;
    bit [1:0]  word_index;
    bit        last_word;
  } digest_word_t;

  class digest_scoreboard;
    bit [31:0]    chain [4];
    bit [31:0]    block [16];
    bit [63:0]    bit_count;
    digest_word_t expected_words [$];
    int           errors;

    function new();
      chain     = CHAIN_INIT;
      bit_count = '0;
      errors    = 0;
      foreach (block[i]) block[i] = '0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] md5 tb error: %s", $time, msg);
    endtask

    function int pending();
      return expected_words.size();
    endfunction

    function bit [31:0] rotl(bit [31:0] x, int s);
      return (x << s) | (x >> (32 - s));
    endfunction

    // Run the 64 rounds on the buffered block and fold into the chain
    function void compress_block();
      bit [31:0] a, b, c, d, f, mix, hold;
      int        g, quarter;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
        quarter = r / 16;
        case (quarter)
          0: begin
            f = (b & c) | (~b & d);
            g = r;
          end
          1: begin
            f = (b & d) | (c & ~d);
            g = (1 + 5 * r) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            g = (5 + 3 * r) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            g = (7 * r) % 16;
          end
        endcase
        mix  = a + f + MIX_K[r] + block[g];
        hold = d;
        d    = c;
        c    = b;
        b    = b + rotl(mix, ROUND_SHIFT[quarter * 4 + r % 4]);
        a    = hold;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    // Store one byte little-endian; compress when the block fills
    function int put_byte(int pos, bit [7:0] value);
      block[pos / 4][(pos % 4) * 8 +: 8] = value;
      pos = (pos + 1) % BLOCK_BYTES;
      if (pos == 0) compress_block();
      return pos;
    endfunction

    // Absorb one accepted input transaction and queue any digest it causes
    function void absorb_item(bit [7:0] data_byte, bit has_byte, bit end_of_message);
      int           pos;
      digest_word_t w;
      if (has_byte) begin
        void'(put_byte(int'(bit_count[8:3]), data_byte));
        bit_count += 64'd8;
      end
      if (!end_of_message) return;
      // Pad to the length slot, append the bit count, final compression
      pos = put_byte(int'(bit_count[8:3]), PAD_MARK);
      while (pos != LENGTH_OFFSET) pos = put_byte(pos, 8'h00);
      block[14] = bit_count[31:0];
      block[15] = bit_count[63:32];
      compress_block();
      for (int k = 0; k < 4; k++) begin
        w.word       = chain[k];
        w.word_index = 2'(k);
        w.last_word  = (2'(k) == FINAL_WORD_IDX);
        expected_words.push_back(w);
      end
      chain     = CHAIN_INIT;
      bit_count = '0;
    endfunction

    // Compare one output transaction with the oldest expected digest word
    task check_word(bit [31:0] word, bit [1:0] word_index, bit last_word);
      digest_word_t exp_w;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %h index %0d", word, word_index));
        return;
      end
      exp_w = expected_words.pop_front();
      if (word != exp_w.word)
        report_mismatch($sformatf("digest word %h, predicted %h (index %0d)",
                                  word, exp_w.word, exp_w.word_index));
      if (word_index != exp_w.word_index)
        report_mismatch($sformatf("word index %0d, predicted %0d",
                                  word_index, exp_w.word_index));
      if (last_word != exp_w.last_word)
        report_mismatch($sformatf("last flag %0b, predicted %0b (index %0d)",
                                  last_word, exp_w.last_word, exp_w.word_index));
    endtask
  endclass

endpackage

module tb_md5_message_digest;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;  // [7:0] data_byte
  logic        s_tuser  = 1'b0;   // [0] has_byte
  logic        s_tlast  = 1'b0;   // end_of_message
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // [31:0] digest_word, [33:32] word_index, [39:34] zero
  logic        m_tlast;           // last_word

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int items_sent    = 0;
  int msgs_sent     = 0;
  int random_base;

  tb_md5_message_digest_pkg::digest_scoreboard board;

  md5_message_digest u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  // Stall the digest output at random
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Check every accepted digest transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_word(m_tdata[31:0], m_tdata[33:32], m_tlast);
  end

  function void set_idling(int phase);
    case (phase)
      0: begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end
      1: begin
        src_idle_pct  = 52;
        snk_stall_pct = 0;
      end
      2: begin
        src_idle_pct  = 0;
        snk_stall_pct = 52;
      end
      default: begin
        src_idle_pct  = 17;
        snk_stall_pct = 17;
      end
    endcase
  endfunction

  // Offer one byte transaction; entered and left just after a falling edge
  task automatic send_item(bit [7:0] data_byte, bit has_byte, bit end_of_message);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom_range(255));
      s_tuser  <= 1'($urandom_range(1));
      s_tlast  <= 1'($urandom_range(1));
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data_byte;
    s_tuser  <= has_byte;
    s_tlast  <= end_of_message;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.absorb_item(data_byte, has_byte, end_of_message);
    if (has_byte || end_of_message) items_sent++;
    if (end_of_message) msgs_sent++;
    @(negedge clk);
  endtask

  // Send a message of random bytes, with idle transactions mixed in
  task automatic send_message(int len, bit byte_on_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, byte_on_end && (i == len - 1));
    end
    if (!byte_on_end || len == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Mostly short messages; some land on the padding and block boundaries
  function int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 20) begin
      case ($urandom_range(9))
        0: return 55;
        1: return 56;
        2: return 57;
        3: return 63;
        4: return 64;
        5: return 65;
        6: return 119;
        7: return 120;
        8: return 127;
        default: return 128;
      endcase
    end
    if (r < 26) return 0;
    return $urandom_range(24, 1);
  endfunction

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty message, idle transactions, extreme bytes, short messages
    set_idling(0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);

    // Random messages across the idling phases
    random_base = items_sent;
    while (items_sent - random_base < 360 || msgs_sent < 16) begin
      set_idling(((items_sent - random_base) / 90) % 4);
      send_message(pick_length(), 1'($urandom_range(1)));
    end
    s_tvalid <= 1'b0;

    // Drain outstanding digests, then watch for stray output
    while (board.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    if (board.errors == 0)
      $display("md5_message_digest: match");
    else
      $display("md5_message_digest: mismatch");
    $finish;
  end

  // Hang guard
  initial begin
    #(20 * 1000000);
    $display("md5_message_digest: mismatch");
    $finish;
  end

endmodule

// ----- md5_message_digest.f -----
+incdir+rtl/core
rtl/core/md5_pkg.sv
rtl/core/md5_round.sv
rtl/core/md5_message_digest.sv
rtl/core/md5_message_digest_chk.sv
test/tb_md5_message_digest.sv
